>>> hdl/wpd_pkg.sv
package wpd_pkg;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_START_FRAME   = 2'd0;
	localparam cfg_idx_t CFG_END_FRAME     = 2'd1;
	localparam cfg_idx_t CFG_WINDOW_FRAMES = 2'd2;
	localparam cfg_idx_t CFG_STEREO_MODE   = 2'd3;

	// window length register width and its reset value
	localparam int WIN_BITS = 16;
	typedef logic [WIN_BITS-1:0] win_t;
	localparam win_t WIN_RESET = 16'd256;

	// number of results one frame can cause, as a push count
	typedef logic [1:0] push_cnt_t;
	localparam push_cnt_t PUSH_NONE = 2'd0;
	localparam push_cnt_t PUSH_ONE  = 2'd1;
	localparam push_cnt_t PUSH_TWO  = 2'd2;

endpackage

>>> hdl/waveform_peak_decimator_unit.sv
// windowed peak decimator for waveform overviews
//
//  channel   handshake              payload
//  -------   ---------------------  -------------------------------------------
//  in        in_valid / in_ready    left_sample, right_sample, last_frame
//  out       out_valid / out_ready  end_marker, peak_index, peak_value, run_last
//  cfg       cfg_we (no wait)       cfg_index, cfg_data
//
// one frame per cycle sustained while the result queue has room; an in
// transaction lands in the input register, and its results enter the result
// queue when the held frame steps and show on out from the queue.
// a last-frame transaction with a partial window open makes two results,
// which leave one after the other through the single out port.
// in_ready drops only when the four-entry result queue lacks room for the
// frame held in the input register, so out stalls reach in through the queue.
// arst_n clears span state, configuration and the queue; no clearing pass.
module waveform_peak_decimator_unit #(
	parameter int INDEX_BITS  = 24,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// frame input
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          last_frame,
	// peak output
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          end_marker,
	output logic [INDEX_BITS-1:0]         peak_index,
	output logic signed [SAMPLE_BITS-1:0] peak_value,
	output logic                          run_last,
	// configuration writes
	input  logic                          cfg_we,
	input  wpd_pkg::cfg_idx_t             cfg_index,
	input  logic [((INDEX_BITS + 1 > wpd_pkg::WIN_BITS) ?
		(INDEX_BITS + 1) : wpd_pkg::WIN_BITS)-1:0] cfg_data
);

	localparam int CB = INDEX_BITS + 1;
	localparam int RW = INDEX_BITS + SAMPLE_BITS + 2;

	// configuration registers
	logic [INDEX_BITS-1:0] start_frame_q;
	logic [CB-1:0]         end_frame_q;
	wpd_pkg::win_t         window_frames_q;
	logic                  stereo_mode_q;

	// input register
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] left_s1;
	logic [SAMPLE_BITS-1:0] right_s1;
	logic                   last_s1;

	wpd_pkg::push_cnt_t push_n;
	logic               step;
	logic [RW-1:0]      res0;
	logic [RW-1:0]      res1;
	logic [RW-1:0]      head;
	logic [2:0]         fill;
	logic [2:0]         fill_after;
	logic               pop;

	// configuration writes, each index selects one register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_frame_q   <= '0;
			end_frame_q     <= {1'b1, {INDEX_BITS{1'b0}}};
			window_frames_q <= wpd_pkg::WIN_RESET;
			stereo_mode_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wpd_pkg::CFG_START_FRAME:   start_frame_q   <= cfg_data[INDEX_BITS-1:0];
				wpd_pkg::CFG_END_FRAME:     end_frame_q     <= cfg_data[CB-1:0];
				wpd_pkg::CFG_WINDOW_FRAMES: window_frames_q <= cfg_data[wpd_pkg::WIN_BITS-1:0];
				wpd_pkg::CFG_STEREO_MODE:   stereo_mode_q   <= cfg_data[0];
			endcase
		end
	end

	// the held frame moves on once the queue can take all of its results
	assign fill_after = fill + {1'b0, push_n};
	assign step       = valid_s1 && (fill_after <= 3'd4);
	assign in_ready   = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			left_s1  <= left_sample;
			right_s1 <= right_sample;
			last_s1  <= last_frame;
		end
	end

	wpd_frame #(
		.INDEX_BITS  (INDEX_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_frame (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.left_sample   (left_s1),
		.right_sample  (right_s1),
		.last_frame    (last_s1),
		.start_frame   (start_frame_q),
		.end_frame     (end_frame_q),
		.window_frames (window_frames_q),
		.stereo_mode   (stereo_mode_q),
		.push_n        (push_n),
		.res0          (res0),
		.res1          (res1)
	);

	// results enter the queue only on a step of the held frame
	wpd_rbuf #(
		.W (RW)
	) u_rbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (step ? push_n : wpd_pkg::PUSH_NONE),
		.push0  (res0),
		.push1  (res1),
		.pop    (pop),
		.head   (head),
		.count  (fill)
	);

	assign out_valid = (fill != 3'd0);
	assign pop       = out_valid && out_ready;

	// result layout: end marker, index, value, last-of-frame flag
	assign end_marker = head[RW-1];
	assign peak_index = head[RW-2 -: INDEX_BITS];
	assign peak_value = head[SAMPLE_BITS:1];
	assign run_last   = head[0];

	// queue never holds more than its four entries
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= 3'd4)
		else $error("result queue over its depth");

	// backpressure on in comes only from a frame held in the input register
	a_ready_src: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("in_ready low with empty input register");

	// an end code is always the final result of its frame and carries no peak
	a_end_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_marker |-> run_last && peak_index == '0 && peak_value == '0)
		else $error("malformed end code");

	// a popped result that was not last of its frame is followed by another
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !run_last |=> out_valid)
		else $error("first of a result pair without its follower");

endmodule

>>> hdl/wpd_frame.sv
// per-frame peak tracking: span/window state and up to two results per frame
module wpd_frame #(
	parameter int INDEX_BITS  = 24,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic signed [SAMPLE_BITS-1:0] left_sample,
	input  logic signed [SAMPLE_BITS-1:0] right_sample,
	input  logic                          last_frame,
	input  logic [INDEX_BITS-1:0]         start_frame,
	input  logic [INDEX_BITS:0]           end_frame,
	input  wpd_pkg::win_t                 window_frames,
	input  logic                          stereo_mode,
	output wpd_pkg::push_cnt_t            push_n,
	output logic [INDEX_BITS+SAMPLE_BITS+1:0] res0,
	output logic [INDEX_BITS+SAMPLE_BITS+1:0] res1
);

	localparam int CB = INDEX_BITS + 1;

	logic [CB-1:0]          frame_counter_q;
	wpd_pkg::win_t          window_fill_q;
	logic [INDEX_BITS-1:0]  best_index_q;
	logic [SAMPLE_BITS-1:0] best_value_q;
	logic                   span_done_q;

	logic signed [SAMPLE_BITS:0] mix_sum;
	logic [SAMPLE_BITS-1:0]      mono;
	logic [SAMPLE_BITS-1:0]      mag_new;
	logic [SAMPLE_BITS-1:0]      mag_best;
	logic [CB:0]                 cnt_p1;
	logic                        hit_end;
	logic                        in_span;
	logic                        take;
	logic [INDEX_BITS-1:0]       nb_index;
	logic [SAMPLE_BITS-1:0]      nb_value;
	wpd_pkg::win_t               fill_inc;
	wpd_pkg::win_t               win_eff;
	logic                        close_win;
	logic                        pending;

	// floor((l + r) / 2) is an arithmetic shift of the widened sum
	assign mix_sum = {left_sample[SAMPLE_BITS-1], left_sample}
		+ {right_sample[SAMPLE_BITS-1], right_sample};
	assign mono = stereo_mode ? mix_sum[SAMPLE_BITS:1] : left_sample;

	// magnitudes as unsigned, the most negative value maps to 2^(n-1)
	assign mag_new  = mono[SAMPLE_BITS-1] ? (~mono + 1'b1) : mono;
	assign mag_best = best_value_q[SAMPLE_BITS-1] ? (~best_value_q + 1'b1) : best_value_q;

	assign cnt_p1  = {1'b0, frame_counter_q} + 1'b1;
	assign hit_end = (cnt_p1 == {1'b0, end_frame});
	assign in_span = !span_done_q && (frame_counter_q >= {1'b0, start_frame})
		&& (frame_counter_q < end_frame);

	assign take     = (window_fill_q == '0) || (mag_new > mag_best);
	assign nb_index = take ? frame_counter_q[INDEX_BITS-1:0] : best_index_q;
	assign nb_value = take ? mono : best_value_q;

	assign win_eff   = (window_frames == '0) ? wpd_pkg::win_t'(1) : window_frames;
	assign fill_inc  = window_fill_q + 1'b1;
	assign close_win = in_span && ((fill_inc >= win_eff) || hit_end);
	assign pending   = (window_fill_q != '0);

	always_comb begin
		res1 = {1'b1, {INDEX_BITS{1'b0}}, {SAMPLE_BITS{1'b0}}, 1'b1};
		if (last_frame) begin
			if (pending) begin
				push_n = wpd_pkg::PUSH_TWO;
				res0   = {1'b0, best_index_q, best_value_q, 1'b0};
			end else begin
				push_n = wpd_pkg::PUSH_ONE;
				res0   = {1'b1, {INDEX_BITS{1'b0}}, {SAMPLE_BITS{1'b0}}, 1'b1};
			end
		end else begin
			push_n = close_win ? wpd_pkg::PUSH_ONE : wpd_pkg::PUSH_NONE;
			res0   = {1'b0, nb_index, nb_value, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_counter_q <= '0;
			window_fill_q   <= '0;
			best_index_q    <= '0;
			best_value_q    <= '0;
			span_done_q     <= 1'b0;
		end else if (step) begin
			if (last_frame) begin
				frame_counter_q <= '0;
				window_fill_q   <= '0;
				best_index_q    <= '0;
				best_value_q    <= '0;
				span_done_q     <= 1'b0;
			end else begin
				if (in_span) begin
					best_index_q  <= nb_index;
					best_value_q  <= nb_value;
					window_fill_q <= close_win ? '0 : fill_inc;
					if (close_win && hit_end) begin
						span_done_q <= 1'b1;
					end
				end
				// counter saturates at all ones
				if (frame_counter_q != {CB{1'b1}}) begin
					frame_counter_q <= cnt_p1[CB-1:0];
				end
			end
		end
	end

endmodule

>>> hdl/wpd_rbuf.sv
// four-entry result queue, takes up to two results per cycle, gives one
module wpd_rbuf #(
	parameter int W = 42
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wpd_pkg::push_cnt_t push_n,
	input  logic [W-1:0]       push0,
	input  logic [W-1:0]       push1,
	input  logic               pop,
	output logic [W-1:0]       head,
	output logic [2:0]         count
);

	logic [W-1:0] mem_q [4];
	logic [1:0]   wptr_q;
	logic [1:0]   rptr_q;
	logic [2:0]   count_q;
	logic [1:0]   wptr_p1;

	assign wptr_p1 = wptr_q + 1'b1;
	assign head    = mem_q[rptr_q];
	assign count   = count_q;

	always_ff @(posedge clk) begin
		if (push_n != wpd_pkg::PUSH_NONE) begin
			mem_q[wptr_q] <= push0;
		end
		if (push_n == wpd_pkg::PUSH_TWO) begin
			mem_q[wptr_p1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + push_n;
			rptr_q  <= rptr_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int INDEX_W        = 24;
	localparam int SAMPLE_W       = 16;
	localparam int CFG_W          = 25;
	localparam int HOLD_CYCLES    = 240;   // long receiver hold-off, fills the result queue
	localparam int SETTLE_CYCLES  = 8;     // frames with no result may still be in flight
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction on either side

	// one peak record as it appears on the out channel
	typedef struct {
		logic                       end_marker;
		logic [INDEX_W-1:0]         peak_index;
		logic signed [SAMPLE_W-1:0] peak_value;
		logic                       run_last;
	} peak_t;

	// predictor of the decimator plus the queue of peaks still owed by the block
	class peak_scoreboard;
		// configuration copy
		logic [INDEX_W-1:0]  start_frame;
		logic [CFG_W-1:0]    end_frame;
		wpd_pkg::win_t       window_frames;
		logic                stereo_mode;
		// span state
		logic [CFG_W-1:0]             frame_counter;
		logic [wpd_pkg::WIN_BITS-1:0] window_fill;
		logic [INDEX_W-1:0]           best_index;
		logic signed [SAMPLE_W-1:0]   best_value;
		logic                         span_done;

		peak_t owed_peaks[$];
		int    mismatches;

		function new();
			start_frame   = '0;
			end_frame     = 25'd16777216;
			window_frames = wpd_pkg::WIN_RESET;
			stereo_mode   = 1'b0;
			frame_counter = '0;
			window_fill   = '0;
			best_index    = '0;
			best_value    = '0;
			span_done     = 1'b0;
			mismatches    = 0;
		endfunction

		function void write_reg(wpd_pkg::cfg_idx_t idx, logic [CFG_W-1:0] value);
			case (idx)
				wpd_pkg::CFG_START_FRAME:   start_frame = value[INDEX_W-1:0];
				wpd_pkg::CFG_END_FRAME:     end_frame = value;
				wpd_pkg::CFG_WINDOW_FRAMES: window_frames = value[wpd_pkg::WIN_BITS-1:0];
				wpd_pkg::CFG_STEREO_MODE:   stereo_mode = value[0];
				default: ;
			endcase
		endfunction

		function int magnitude(int v);
			return (v < 0) ? -v : v;
		endfunction

		function void push_peak(logic em, logic [INDEX_W-1:0] idx,
			logic signed [SAMPLE_W-1:0] val, logic rl);
			peak_t p;
			p.end_marker = em;
			p.peak_index = idx;
			p.peak_value = val;
			p.run_last   = rl;
			owed_peaks.push_back(p);
		endfunction

		// advance the span by one accepted frame and queue the peaks it causes
		function void note_frame(logic signed [SAMPLE_W-1:0] left,
			logic signed [SAMPLE_W-1:0] right, logic mark);
			int          mono;
			int unsigned span_len;
			logic [CFG_W-1:0] idx;
			logic [CFG_W:0]   idx_p1;
			span_len = (window_frames == '0) ? 1 : 32'(window_frames);
			idx = frame_counter;
			idx_p1 = {1'b0, idx} + 1'b1;
			// floor of the mean in stereo mode
			if (stereo_mode)
				mono = (int'(left) + int'(right)) >>> 1;
			else
				mono = int'(left);

			if (mark) begin
				if (window_fill != '0)
					push_peak(1'b0, best_index, best_value, 1'b0);
				push_peak(1'b1, '0, '0, 1'b1);
				frame_counter = '0;
				window_fill   = '0;
				best_index    = '0;
				best_value    = '0;
				span_done     = 1'b0;
				return;
			end

			if (!span_done && idx >= {1'b0, start_frame} && idx < end_frame) begin
				// ties keep the earlier sample
				if (window_fill == '0 || magnitude(mono) > magnitude(int'(best_value))) begin
					best_index = idx[INDEX_W-1:0];
					best_value = mono[SAMPLE_W-1:0];
				end
				window_fill = window_fill + 1'b1;
				if (32'(window_fill) >= span_len || idx_p1 == {1'b0, end_frame}) begin
					push_peak(1'b0, best_index, best_value, 1'b1);
					window_fill = '0;
					if (idx_p1 == {1'b0, end_frame})
						span_done = 1'b1;
				end
			end

			// counter saturates
			if (frame_counter != '1)
				frame_counter = frame_counter + 1'b1;
		endfunction

		function void compare_field(string field, logic signed [31:0] want,
			logic signed [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0d, actual %0d", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_peak(logic em, logic [INDEX_W-1:0] idx,
			logic signed [SAMPLE_W-1:0] val, logic rl);
			peak_t want;
			if (owed_peaks.size() == 0) begin
				$error("unexpected peak transaction: end_marker %0d index %0d value %0d",
					em, idx, val);
				mismatches++;
				return;
			end
			want = owed_peaks.pop_front();
			compare_field("end_marker", 32'(want.end_marker), 32'(em));
			compare_field("peak_index", 32'(want.peak_index), 32'(idx));
			compare_field("peak_value", 32'(want.peak_value), 32'(val));
			compare_field("run_last", 32'(want.run_last), 32'(rl));
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                       last_frame;
	logic                       out_valid;
	logic                       out_ready;
	logic                       end_marker;
	logic [INDEX_W-1:0]         peak_index;
	logic signed [SAMPLE_W-1:0] peak_value;
	logic                       run_last;
	logic                       cfg_we;
	wpd_pkg::cfg_idx_t          cfg_index;
	logic [CFG_W-1:0]           cfg_data;

	peak_scoreboard sb = new();

	// idle shares in percent, read by the sender and receiver
	int tx_pct = 0;
	int rx_pct = 0;
	// request for one long receiver hold-off
	bit hold_req = 1'b0;
	int quiet_cycles = 0;

	waveform_peak_decimator_unit #(
		.INDEX_BITS (INDEX_W),
		.SAMPLE_BITS(SAMPLE_W)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.left_sample (left_sample),
		.right_sample(right_sample),
		.last_frame  (last_frame),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.end_marker  (end_marker),
		.peak_index  (peak_index),
		.peak_value  (peak_value),
		.run_last    (run_last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// sample both channels at the rising edge; a result is checked before the
	// frame accepted at the same edge is noted, it cannot be one of its peaks
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_peak(end_marker, peak_index, peak_value, run_last);
		if (arst_n && in_valid && in_ready)
			sb.note_frame(left_sample, right_sample, last_frame);
	end

	// watchdog: a run of cycles with no transaction at all means a hang
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		int stall;
		stall = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				// counted here while the sender keeps offering frames
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
				stall = $urandom_range(0, 13);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return '0;
			3: return '1;
			// small values make magnitude ties likely
			4, 5: return SAMPLE_W'($urandom_range(0, 16) - 8);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic int idle_share();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// offer one frame, with an optional idle burst first; returns on acceptance
	task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
		input logic signed [SAMPLE_W-1:0] right, input logic mark);
		int gap;
		if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
			gap = $urandom_range(1, 14);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		left_sample  <= left;
		right_sample <= right;
		last_frame   <= mark;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering, wait for every owed peak, then let trailing frames settle
	task automatic drain_queue();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.owed_peaks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_register(input wpd_pkg::cfg_idx_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [INDEX_W-1:0] span_start,
		input logic [CFG_W-1:0] span_end, input wpd_pkg::win_t win, input logic stereo);
		set_register(wpd_pkg::CFG_START_FRAME, {1'b0, span_start});
		set_register(wpd_pkg::CFG_END_FRAME, span_end);
		set_register(wpd_pkg::CFG_WINDOW_FRAMES, CFG_W'(win));
		set_register(wpd_pkg::CFG_STEREO_MODE, CFG_W'(stereo));
	endtask

	// one setting: mostly whole files ending in a marked frame, some noise runs
	task automatic run_phase(input logic [INDEX_W-1:0] span_start,
		input logic [CFG_W-1:0] span_end, input wpd_pkg::win_t win, input logic stereo,
		input int frames, input int max_len, input int tx_idle, input int rx_idle,
		input bit hold);
		int sent;
		int burst;
		int len;
		drain_queue();
		configure(span_start, span_end, win, stereo);
		tx_pct = tx_idle;
		rx_pct = rx_idle;
		if (hold)
			hold_req = 1'b1;
		sent = 0;
		while (sent < frames) begin
			if ($urandom_range(0, 7) == 0) begin
				// noise: short run with random end marks
				burst = $urandom_range(1, 6);
				repeat (burst) send_frame(rand_sample(), rand_sample(),
					1'($urandom_range(0, 1)));
				sent += burst;
			end else begin
				len = $urandom_range(1, max_len);
				for (int k = 1; k <= len; k++)
					send_frame(rand_sample(), rand_sample(), k == len);
				sent += len;
			end
		end
	endtask

	initial begin : stimulus
		logic [INDEX_W-1:0] s;
		logic [CFG_W-1:0]   e;
		wpd_pkg::win_t      w;
		in_valid     = 1'b0;
		left_sample  = '0;
		right_sample = '0;
		last_frame   = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = wpd_pkg::CFG_START_FRAME;
		cfg_data     = '0;
		arst_n       = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: span 1..8, windows of three, stereo mix
		tx_pct = 15;
		rx_pct = 15;
		configure(24'd1, 25'd9, 16'd3, 1'b1);
		send_frame(16'sd100, 16'sd100, 1'b0);       // before the span
		send_frame(16'h8000, 16'h8000, 1'b0);       // most negative mix
		send_frame(16'h7FFF, 16'h7FFF, 1'b0);       // smaller magnitude, no replace
		send_frame(16'sd5, -16'sd5, 1'b0);          // full window closes here
		send_frame(-16'sd1, 16'sd0, 1'b0);          // mix floors to -1
		send_frame(16'sd1, 16'sd0, 1'b0);           // mix floors to 0
		send_frame(16'sd3, -16'sd4, 1'b0);          // tie at magnitude one, first kept
		send_frame(16'sd7, 16'sd7, 1'b0);
		send_frame(-16'sd7, -16'sd7, 1'b0);         // tie, and the span end closes it
		send_frame(16'h7FFF, 16'h8000, 1'b0);       // after the span
		send_frame(16'sd0, 16'sd0, 1'b1);           // end marker alone
		send_frame(16'sd9, 16'sd9, 1'b1);           // marked frame right after rearm
		send_frame(16'sd11, 16'sd11, 1'b0);
		send_frame(16'sd20, -16'sd30, 1'b0);
		send_frame(16'sd1, 16'sd1, 1'b1);           // partial window flushed before the marker
		drain_queue();

		// directed: mono, window of zero acts as one, short span
		configure(24'd0, 25'd3, 16'd0, 1'b0);
		send_frame(16'h8000, 16'h7FFF, 1'b0);       // right channel ignored
		send_frame(16'h7FFF, 16'h8000, 1'b0);
		send_frame(-16'sd1, 16'sd5, 1'b0);          // last frame of the span
		send_frame(16'sd5, 16'sd5, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b1);

		// one peak per frame, long receiver hold-off so the input stalls; then windows of seven
		run_phase(24'd0, 25'd16777216, 16'd1, 1'b0, 150, 40, 0, idle_share(), 1'b1);
		run_phase(24'd3, 25'd150, 16'd7, 1'b1, 150, 180, idle_share(), idle_share(), 1'b0);
		// empty spans: start at its maximum, then end at zero
		run_phase(24'hFFFFFF, 25'd16777216, 16'hFFFF, 1'b1, 60, 30,
			idle_share(), idle_share(), 1'b0);
		run_phase(24'd0, 25'd0, 16'd5, 1'b0, 60, 30, idle_share(), idle_share(), 1'b0);
		// widest window, only marked frames flush; then a window of zero
		run_phase(24'd0, 25'd16777216, 16'hFFFF, 1'b1, 120, 60,
			idle_share(), idle_share(), 1'b0);
		run_phase(24'd0, 25'd16777216, 16'd0, 1'b1, 80, 20, idle_share(), idle_share(), 1'b0);

		for (int p = 0; p < 6; p++) begin
			s = INDEX_W'($urandom_range(0, 40));
			e = ($urandom_range(0, 3) == 0) ? 25'd16777216
				: CFG_W'({1'b0, s} + $urandom_range(1, 120));
			w = ($urandom_range(0, 3) == 0) ? wpd_pkg::win_t'($urandom_range(0, 2))
				: wpd_pkg::win_t'($urandom_range(1, 16));
			if (p == 5) begin
				// closing stretch without idling on either side
				run_phase(s, e, w, 1'($urandom_range(0, 1)), 110,
					(e > 200) ? 60 : int'(e) + 20, 0, 0, 1'b0);
			end else begin
				run_phase(s, e, w, 1'($urandom_range(0, 1)), 80,
					(e > 200) ? 60 : int'(e) + 20, idle_share(), idle_share(), 1'b0);
			end
		end

		drain_queue();
		if (sb.mismatches == 0 && sb.owed_peaks.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/wpd_pkg.sv
hdl/wpd_frame.sv
hdl/wpd_rbuf.sv
hdl/waveform_peak_decimator_unit.sv
tb/testbench.sv
